[design/upe_pkg.sv]
package upe_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] EscLimit  = 8'h7f;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2b;
  localparam logic [ByteW-1:0] ChSlash   = 8'h2f;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChNul     = 8'h00;

  // how the back end renders a queued byte
  typedef enum logic {
    KIND_PASS,
    KIND_ESCAPE
  } upe_kind_e;

  // character position inside an escape sequence
  typedef enum logic [1:0] {
    STEP_FIRST,
    STEP_HIGH,
    STEP_LOW
  } upe_step_e;

  typedef struct packed {
    upe_kind_e        kind;
    logic [ByteW-1:0] data;     // output char for pass, raw byte for escape
    logic             str_end;  // last character of the string
  } upe_entry_t;

  // queue read side as seen by the back end
  typedef struct packed {
    logic       valid;
    upe_entry_t entry;
  } upe_head_t;

  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
    logic [ByteW-1:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

[design/url_percent_encoder.sv]
// channel   dir  tdata                 tlast        tuser
// s_axis    in   [7:0] in_byte         final_byte   -
// m_axis    out  [7:0] out_char        string_end   run_end
//
// one output character per cycle while m_axis is ready and work is queued; a passed
// byte becomes one character, an escaped byte three, all through the single character register of the back end
// the front classifies one byte per cycle, while the queue has room, into a queue of QUEUE_DEPTH entries
// s_axis_tready drops only while that queue is full
// m_axis stalls hold the output register; the front keeps filling the queue
// reset clears the group count, the queue pointers and the output valid
module url_percent_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,   // string_end
  output logic       m_axis_tuser    // run_end
);

  // front to queue
  logic                 push;
  logic                 q_full;
  upe_pkg::upe_entry_t  entry;

  // queue to back
  upe_pkg::upe_head_t   head;
  logic                 pop;

  upe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .entry_o    (entry)
  );

  // classified bytes waiting for expansion
  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .head_o  (head)
  );

  // expands each entry into one or three characters
  upe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_char_o    (m_axis_tdata),
    .out_run_end_o (m_axis_tuser),
    .out_str_end_o (m_axis_tlast)
  );

endmodule

[design/upe_front.sv]
module upe_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [upe_pkg::ByteW-1:0]       in_byte_i,
  input  logic                            in_final_i,
  input  logic                            q_full_i,
  output logic                            in_ready_o,
  output logic                            push_o,
  output upe_pkg::upe_entry_t             entry_o
);

  logic [1:0] group_left_q, group_left_d;
  logic       is_alnum;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign is_alnum = (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) ||
                    (in_byte_i >= 8'h41 && in_byte_i <= 8'h5a) ||
                    (in_byte_i >= 8'h61 && in_byte_i <= 8'h7a);

  always_comb begin
    group_left_d    = group_left_q;
    entry_o.kind    = upe_pkg::KIND_ESCAPE;
    entry_o.data    = in_byte_i;
    entry_o.str_end = in_final_i;
    if (group_left_q != 2'd0) begin
      group_left_d = group_left_q - 2'd1;
    end else if (in_byte_i > upe_pkg::EscLimit) begin
      group_left_d = 2'd2;
    end else if (is_alnum || in_byte_i == upe_pkg::ChSlash) begin
      entry_o.kind = upe_pkg::KIND_PASS;
    end else if (in_byte_i == upe_pkg::ChSpace) begin
      entry_o.kind = upe_pkg::KIND_PASS;
      entry_o.data = upe_pkg::ChPlus;
    end else if (in_byte_i == upe_pkg::ChNul) begin
      // terminator ends the string regardless of the final flag
      entry_o.kind    = upe_pkg::KIND_PASS;
      entry_o.str_end = 1'b1;
    end
    if (in_final_i) begin
      group_left_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_left_q <= 2'd0;
    end else if (push_o) begin
      group_left_q <= group_left_d;
    end
  end

endmodule

[design/upe_queue.sv]
module upe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  upe_pkg::upe_entry_t  entry_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output upe_pkg::upe_head_t   head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  upe_pkg::upe_entry_t mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_pop;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("pop from an empty queue");

endmodule

[design/upe_back.sv]
module upe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  upe_pkg::upe_head_t          head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [upe_pkg::ByteW-1:0]   out_char_o,
  output logic                        out_run_end_o,
  output logic                        out_str_end_o
);

  upe_pkg::upe_step_e          state_q, state_d;
  logic [upe_pkg::ByteW-1:0]   byte_q, byte_d;
  logic                        send_q, send_d;
  logic                        valid_q, valid_d;
  logic [upe_pkg::ByteW-1:0]   char_q, char_d;
  logic                        rend_q, rend_d;
  logic                        strend_q, strend_d;
  logic                        load;

  // output register free or being drained this cycle
  assign load = !valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    byte_d   = byte_q;
    send_d   = send_q;
    valid_d  = valid_q && !out_ready_i;
    char_d   = char_q;
    rend_d   = rend_q;
    strend_d = strend_q;
    pop_o    = 1'b0;
    if (load) begin
      case (state_q)
        upe_pkg::STEP_FIRST: begin
          if (head_i.valid) begin
            pop_o   = 1'b1;
            valid_d = 1'b1;
            if (head_i.entry.kind == upe_pkg::KIND_PASS) begin
              char_d   = head_i.entry.data;
              rend_d   = 1'b1;
              strend_d = head_i.entry.str_end;
            end else begin
              char_d   = upe_pkg::ChPercent;
              rend_d   = 1'b0;
              strend_d = 1'b0;
              byte_d   = head_i.entry.data;
              send_d   = head_i.entry.str_end;
              state_d  = upe_pkg::STEP_HIGH;
            end
          end
        end
        upe_pkg::STEP_HIGH: begin
          valid_d  = 1'b1;
          char_d   = upe_pkg::hex_digit(byte_q[7:4]);
          rend_d   = 1'b0;
          strend_d = 1'b0;
          state_d  = upe_pkg::STEP_LOW;
        end
        upe_pkg::STEP_LOW: begin
          valid_d  = 1'b1;
          char_d   = upe_pkg::hex_digit(byte_q[3:0]);
          rend_d   = 1'b1;
          strend_d = send_q;
          state_d  = upe_pkg::STEP_FIRST;
        end
        default: begin
          state_d = upe_pkg::STEP_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= upe_pkg::STEP_FIRST;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    send_q   <= send_d;
    char_q   <= char_d;
    rend_q   <= rend_d;
    strend_q <= strend_d;
  end

  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign out_run_end_o = rend_q;
  assign out_str_end_o = strend_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == upe_pkg::STEP_FIRST)
    else $error("queue popped in the middle of an escape");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && strend_q |-> rend_q)
    else $error("string end without run end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.entry.kind == upe_pkg::KIND_ESCAPE |=>
      valid_q && char_q == upe_pkg::ChPercent && state_q == upe_pkg::STEP_HIGH)
    else $error("escape did not start with a percent sign");

endmodule

[tb/sv/upe_checker.sv]
`timescale 1ns / 100ps

module upe_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,
  input  logic       m_axis_tlast_i,
  input  logic       m_axis_tuser_i,
  output int         err_cnt_o,
  output int         pending_o,
  output int         bytes_in_o,
  output int         chars_out_o,
  output int         escaped_o,
  output int         groups_o,
  output int         strings_o
);

  typedef struct packed {
    logic [upe_pkg::ByteW-1:0] ch;
    logic                      run_end;
    logic                      str_end;
  } enc_char_t;

  enc_char_t  expected_chars[$];
  logic [1:0] group_left = '0;
  int         errs = 0;
  int         n_bytes = 0;
  int         n_chars = 0;
  int         n_escaped = 0;
  int         n_groups = 0;
  int         n_strings = 0;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return 8'h41 + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic rend,
                                    input logic send);
    enc_char_t e;
    e.ch      = ch;
    e.run_end = rend;
    e.str_end = send;
    expected_chars.push_back(e);
  endfunction

  function automatic void push_escape(input logic [7:0] b, input logic last);
    push_char(upe_pkg::ChPercent, 1'b0, 1'b0);
    push_char(hex_char(b[7:4]), 1'b0, 1'b0);
    push_char(hex_char(b[3:0]), 1'b1, last);
    n_escaped++;
  endfunction

  function automatic bit is_unreserved(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == upe_pkg::ChSlash;
  endfunction

  // expected characters for one accepted byte, plus the group count update
  function automatic void predict_encoding(input logic [7:0] b, input logic last);
    if (group_left != 2'd0) begin
      group_left = group_left - 2'd1;
      push_escape(b, last);
    end else if (b > upe_pkg::EscLimit) begin
      group_left = 2'd2;
      n_groups++;
      push_escape(b, last);
    end else if (is_unreserved(b)) begin
      push_char(b, 1'b1, last);
    end else if (b == upe_pkg::ChSpace) begin
      push_char(upe_pkg::ChPlus, 1'b1, last);
    end else if (b == upe_pkg::ChNul) begin
      push_char(upe_pkg::ChNul, 1'b1, 1'b1);
    end else begin
      push_escape(b, last);
    end
    if (last) group_left = 2'd0;
  endfunction

  function automatic void compare_char(input logic [7:0] ch, input logic rend,
                                       input logic send);
    enc_char_t e;
    if (expected_chars.size() == 0) begin
      $error("unexpected output beat: out_char %02h run_end %0b string_end %0b",
             ch, rend, send);
      errs++;
      return;
    end
    e = expected_chars.pop_front();
    if (ch !== e.ch) begin
      $error("out_char mismatch: expected %02h, actual %02h", e.ch, ch);
      errs++;
    end
    if (rend !== e.run_end) begin
      $error("run_end mismatch: expected %0b, actual %0b", e.run_end, rend);
      errs++;
    end
    if (send !== e.str_end) begin
      $error("string_end mismatch: expected %0b, actual %0b", e.str_end, send);
      errs++;
    end
    if (e.str_end) n_strings++;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      group_left = '0;
      expected_chars.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        n_bytes++;
        predict_encoding(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        n_chars++;
        compare_char(m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
      end
    end
    // published with nonblocking updates so the stimulus side reads settled values
    err_cnt_o   <= errs;
    pending_o   <= expected_chars.size();
    bytes_in_o  <= n_bytes;
    chars_out_o <= n_chars;
    escaped_o   <= n_escaped;
    groups_o    <= n_groups;
    strings_o   <= n_strings;
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int RandomItems = 285;
  localparam int TailCycles  = 40;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;   // final_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_char
  logic       m_axis_tlast;           // string_end
  logic       m_axis_tuser;           // run_end

  int err_cnt, pending, bytes_in, chars_out, escaped, groups, strings_done;

  // idling controls, switched between stretches of stimulus
  bit src_idle_en  = 1'b0;
  bit sink_stall_en = 1'b0;
  int sink_hold    = 0;
  int random_sent  = 0;

  always #5 clk_i = ~clk_i;

  url_percent_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  upe_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending),
    .bytes_in_o      (bytes_in),
    .chars_out_o     (chars_out),
    .escaped_o       (escaped),
    .groups_o        (groups),
    .strings_o       (strings_done)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // output side back-pressure: random stalls of random length while enabled
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
      sink_hold     <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one input beat; an optional idle gap first, then hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] pick_unreserved();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'(32'h30 + r);
    if (r < 36) return 8'(32'h41 + (r - 10));
    if (r < 62) return 8'(32'h61 + (r - 36));
    return upe_pkg::ChSlash;
  endfunction

  // a plausible string: text, spaces, punctuation, multi-byte utf-8 runs and
  // a little noise, closed by a terminator, the final flag or both
  task automatic send_random_string();
    int         len, kind, n_cont, end_mode, i;
    logic [7:0] lead;
    logic       noisy_last;
    end_mode = $urandom_range(0, 2);
    len      = $urandom_range(1, 12);
    i        = 0;
    while (i < len) begin
      kind = $urandom_range(0, 9);
      i++;
      random_sent++;
      if (kind <= 4) begin
        send_byte(pick_unreserved(), 1'b0);
      end else if (kind == 5) begin
        send_byte(upe_pkg::ChSpace, 1'b0);
      end else if (kind == 6) begin
        send_byte(8'($urandom_range(1, 127)), 1'b0);
      end else if (kind <= 8) begin
        lead   = 8'($urandom_range(8'hc2, 8'hf4));
        n_cont = (lead >= 8'hf0) ? 3 : (lead >= 8'he0) ? 2 : 1;
        send_byte(lead, 1'b0);
        repeat (n_cont) begin
          send_byte(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
          random_sent++;
        end
      end else begin
        // noise: any byte, sometimes with the final flag mid-string
        noisy_last = ($urandom_range(0, 7) == 0);
        send_byte(8'($urandom_range(0, 255)), noisy_last);
      end
    end
    random_sent++;
    case (end_mode)
      0: begin
        send_byte(upe_pkg::ChNul, 1'b0);
      end
      1: begin
        send_byte(8'($urandom_range(1, 255)), 1'b1);
      end
      default: begin
        send_byte(upe_pkg::ChNul, 1'b1);
      end
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pass-through extremes first, with no idling at all
    send_byte("0", 1'b0);
    send_byte("9", 1'b0);
    send_byte("A", 1'b0);
    send_byte("Z", 1'b0);
    send_byte("a", 1'b0);
    send_byte("z", 1'b0);
    send_byte(upe_pkg::ChSlash, 1'b0);
    send_byte(upe_pkg::ChSpace, 1'b0);
    // plain escapes, low and top of the ascii range
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    send_byte("-", 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b0);
    // group opener, zero inside the group, all-ones inside the group
    send_byte(8'h80, 1'b0);
    send_byte(upe_pkg::ChNul, 1'b0);
    send_byte(8'hff, 1'b0);
    // zero outside a group terminates the string
    send_byte(upe_pkg::ChNul, 1'b0);
    // group cut short by the final flag, next byte passes through
    send_byte(8'hc3, 1'b1);
    send_byte("b", 1'b0);
    // final flag on a space, on a zero and on an escaped byte
    send_byte(upe_pkg::ChSpace, 1'b1);
    send_byte(upe_pkg::ChNul, 1'b1);
    send_byte("~", 1'b1);
    // complete three-byte group ending the string
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b1);

    // random strings; idling switched per string, with quiet stretches
    while (random_sent < RandomItems) begin
      src_idle_en   = ($urandom_range(0, 3) != 0);
      sink_stall_en = ($urandom_range(0, 3) != 0);
      send_random_string();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d input bytes (%0d escaped, %0d utf-8 groups opened)",
             bytes_in, escaped, groups);
    $display("checked %0d output characters across %0d finished strings",
             chars_out, strings_done);
    if (err_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
